/* hw/rtl/ritpc_pkg.sv */
// shared types, constants and fixed-point helpers for the range image to point cloud unit
package ritpc_pkg;

  localparam int unsigned MaxPitchSamples = 1024;
  localparam int unsigned MaxYawSamples   = 4096;
  localparam int unsigned RowW            = 10;
  localparam int unsigned ColW            = 12;
  localparam int unsigned DistW           = 24;
  localparam int unsigned CoordW          = 25;
  localparam int unsigned AngW            = 16;
  localparam int unsigned QueueDepth      = 2;

  localparam logic [23:0] CoordMax = 24'hFFFFFF;

  // q30 polynomial coefficients for sin(pi/2 * u)
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598668;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;

  // configuration register indexes
  localparam logic [2:0] RegNumPitch  = 3'd0;
  localparam logic [2:0] RegNumYaw    = 3'd1;
  localparam logic [2:0] RegPitchStep = 3'd2;
  localparam logic [2:0] RegYawStep   = 3'd3;
  localparam logic [2:0] RegPitchRng  = 3'd4;
  localparam logic [2:0] RegYawRng    = 3'd5;
  localparam logic [2:0] RegMaxDist   = 3'd6;
  localparam logic [2:0] RegMinHeight = 3'd7;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_INIT,
    ST_POLY,
    ST_SIN_FIN,
    ST_Y,
    ST_Y_FIN,
    ST_XZ_A,
    ST_XZ_B,
    ST_XZ_FIN,
    ST_OUT
  } be_state_e;

  // one queued sample: distance with its angles and indexes
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [AngW-1:0]  pitch_ang;
    logic [AngW-1:0]  yaw_ang;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
  } sample_t;

  // result of one point
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
  } point_t;

  // queue status toward the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // saturate a magnitude and apply sign, 25-bit two's complement
  function automatic logic [CoordW-1:0] finish(input logic [47:0] mag, input logic neg);
    logic [23:0] m;
    m = (mag > 48'(CoordMax)) ? CoordMax : mag[23:0];
    return neg ? (CoordW)'(-{1'b0, m}) : {1'b0, m};
  endfunction

endpackage

/* hw/rtl/ritpc_front.sv */
// front end: config registers, row/column counters and angle forming
module ritpc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [24:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ritpc_pkg::DistW-1:0]         in_dist_i,
  input  ritpc_pkg::q_status_t                q_stat_i,
  output logic                                q_push_o,
  output ritpc_pkg::sample_t                  q_data_o,
  output logic [23:0]                         max_dist_o,
  output logic [24:0]                         min_height_o
);

  logic [10:0] num_pitch_q;
  logic [12:0] num_yaw_q;
  logic [15:0] pitch_step_q, yaw_step_q, pitch_rng_q, yaw_rng_q;
  logic [23:0] max_dist_q;
  logic [24:0] min_height_q;
  logic [ritpc_pkg::RowW-1:0] row_q, row_d, row_cur;
  logic [ritpc_pkg::ColW-1:0] col_q, col_d, col_cur;
  logic [10:0] rows;
  logic [12:0] cols;
  logic        accept;
  logic [31:0] pprod, yprod;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pitch_q  <= 11'd16;
      num_yaw_q    <= 13'd1800;
      pitch_step_q <= 16'd364;
      yaw_step_q   <= 16'd36;
      pitch_rng_q  <= 16'd5461;
      yaw_rng_q    <= 16'd65535;
      max_dist_q   <= 24'd102400;
      min_height_q <= 25'd102;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ritpc_pkg::RegNumPitch:  num_pitch_q  <= cfg_data_i[10:0];
        ritpc_pkg::RegNumYaw:    num_yaw_q    <= cfg_data_i[12:0];
        ritpc_pkg::RegPitchStep: pitch_step_q <= cfg_data_i[15:0];
        ritpc_pkg::RegYawStep:   yaw_step_q   <= cfg_data_i[15:0];
        ritpc_pkg::RegPitchRng:  pitch_rng_q  <= cfg_data_i[15:0];
        ritpc_pkg::RegYawRng:    yaw_rng_q    <= cfg_data_i[15:0];
        ritpc_pkg::RegMaxDist:   max_dist_q   <= cfg_data_i[23:0];
        ritpc_pkg::RegMinHeight: min_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective counts: zero means one, clamp to maxima
  always_comb begin
    rows = (num_pitch_q == 11'd0) ? 11'd1 :
           (num_pitch_q > 11'(ritpc_pkg::MaxPitchSamples)) ?
           11'(ritpc_pkg::MaxPitchSamples) : num_pitch_q;
    cols = (num_yaw_q == 13'd0) ? 13'd1 :
           (num_yaw_q > 13'(ritpc_pkg::MaxYawSamples)) ?
           13'(ritpc_pkg::MaxYawSamples) : num_yaw_q;
  end

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // counter update with shrunk-frame clearing
  always_comb begin
    row_cur = ({1'b0, row_q} >= rows) ? '0 : row_q;
    col_cur = ({1'b0, col_q} >= cols) ? '0 : col_q;
    row_d = row_cur;
    col_d = col_cur + 1'b1;
    if ({1'b0, col_cur} + 13'd1 >= cols) begin
      col_d = '0;
      row_d = ({1'b0, row_cur} + 11'd1 >= rows) ? '0 : row_cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // angles modulo one turn
  assign pprod = 32'(row_cur) * 32'(pitch_step_q);
  assign yprod = 32'(col_cur) * 32'(yaw_step_q);

  always_comb begin
    q_data_o.distance  = in_dist_i;
    q_data_o.pitch_ang = pprod[15:0] - {1'b0, pitch_rng_q[15:1]};
    q_data_o.yaw_ang   = yprod[15:0] - {1'b0, yaw_rng_q[15:1]};
    q_data_o.row       = row_cur;
    q_data_o.col       = col_cur;
  end

  assign q_push_o     = accept;
  assign max_dist_o   = max_dist_q;
  assign min_height_o = min_height_q;

endmodule

/* hw/rtl/ritpc_queue.sv */
// short queue between front and back end
module ritpc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ritpc_pkg::sample_t   push_data_i,
  input  logic                 pop_i,
  output ritpc_pkg::sample_t   pop_data_o,
  output ritpc_pkg::q_status_t stat_o
);

  ritpc_pkg::sample_t mem_q [ritpc_pkg::QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign pop_data_o   = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'(ritpc_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == 2'd0);

  push_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i) else $error("push into full queue");
  pop_empty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i) else $error("pop from empty queue");
  cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(ritpc_pkg::QueueDepth)) else $error("queue count overflow");

endmodule

/* hw/rtl/ritpc_back.sv */
// back end: shared sine unit and multiplier sequence, filter and output register
module ritpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ritpc_pkg::q_status_t q_stat_i,
  input  ritpc_pkg::sample_t   q_data_i,
  output logic                 q_pop_o,
  input  logic [23:0]          max_dist_i,
  input  logic [24:0]          min_height_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ritpc_pkg::point_t    out_data_o
);

  ritpc_pkg::be_state_e st_q, st_d;
  ritpc_pkg::sample_t   smp_q;
  logic [1:0]  fn_q;       // which sine: sp, cp, sy, cy
  logic [2:0]  step_q;
  logic [32:0] u_q, u2_q, p_q;
  logic        neg_q;
  logic [15:0] sp_q, cp_q, sy_q, cy_q;  // magnitudes
  logic        spn_q, cpn_q, syn_q, cyn_q;
  logic [63:0] prod;
  logic [31:0] ma, mb;
  logic [63:0] acc_q;
  logic        xz_q;
  logic [24:0] y_q, x_q, z_q;
  logic [24:0] y_new;
  logic        out_v_q;
  ritpc_pkg::point_t out_q;
  logic [15:0] ang;
  logic [15:0] t;
  logic [31:0] kcoef;
  logic [32:0] rnd;
  logic [15:0] sres;
  logic        emit;
  logic        out_free;

  // angle for current sine evaluation
  always_comb begin
    case (fn_q)
      2'd0:    ang = smp_q.pitch_ang;
      2'd1:    ang = smp_q.pitch_ang + 16'h4000;
      2'd2:    ang = 16'h0 - smp_q.yaw_ang;
      default: ang = smp_q.yaw_ang + 16'h4000;
    endcase
    t = {2'b0, ang[13:0]};
    if (ang[14]) t = 16'h4000 - t;
  end

  // coefficient for the Horner step
  always_comb begin
    case (step_q)
      3'd0:    kcoef = ritpc_pkg::K7;
      3'd1:    kcoef = ritpc_pkg::K5;
      3'd2:    kcoef = ritpc_pkg::K3;
      default: kcoef = ritpc_pkg::K1;
    endcase
  end

  // single shared multiplier, operands chosen by state
  // x/z: cosine times sine first (30 bits), then times distance
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q)
      ritpc_pkg::ST_SIN_INIT: begin
        ma = {t, 16'h0};
        mb = {t, 16'h0};
      end
      ritpc_pkg::ST_POLY:   begin
        ma = u2_q[31:0];
        mb = p_q[31:0];
      end
      ritpc_pkg::ST_SIN_FIN: begin
        ma = u_q[31:0];
        mb = p_q[31:0];
      end
      ritpc_pkg::ST_Y:      begin
        ma = {8'h0, smp_q.distance};
        mb = {16'h0, sp_q};
      end
      ritpc_pkg::ST_XZ_A:   begin
        ma = {16'h0, cp_q};
        mb = {16'h0, xz_q ? cy_q : sy_q};
      end
      ritpc_pkg::ST_XZ_B:   begin
        ma = {8'h0, smp_q.distance};
        mb = acc_q[31:0];
      end
      default: ;
    endcase
    prod = 64'(ma) * 64'(mb);
    rnd  = 33'(prod[61:30]) + 33'd16384;
    sres = (rnd[32:15] > 18'd32767) ? 16'd32767 : rnd[30:15];
  end

  // y of the current sample, used by the filter in the same cycle it is stored
  assign y_new = ritpc_pkg::finish(48'((acc_q + 64'd16384) >> 15),
                                   spn_q && (sp_q != 16'd0));
  assign emit  = (smp_q.distance <= max_dist_i) && ($signed(y_new) > $signed(min_height_i));

  // output slot free when empty or being taken
  assign out_free = !out_v_q || out_ready_i;

  // next state
  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    unique case (st_q)
      ritpc_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          st_d    = ritpc_pkg::ST_SIN_INIT;
        end
      end
      ritpc_pkg::ST_SIN_INIT: st_d = ritpc_pkg::ST_POLY;
      ritpc_pkg::ST_POLY:
        if (step_q == 3'd3) st_d = ritpc_pkg::ST_SIN_FIN;
      ritpc_pkg::ST_SIN_FIN:
        st_d = (fn_q == 2'd3) ? ritpc_pkg::ST_Y : ritpc_pkg::ST_SIN_INIT;
      ritpc_pkg::ST_Y:      st_d = ritpc_pkg::ST_Y_FIN;
      ritpc_pkg::ST_Y_FIN:  st_d = emit ? ritpc_pkg::ST_XZ_A : ritpc_pkg::ST_IDLE;
      ritpc_pkg::ST_XZ_A:   st_d = ritpc_pkg::ST_XZ_B;
      ritpc_pkg::ST_XZ_B:   st_d = ritpc_pkg::ST_XZ_FIN;
      ritpc_pkg::ST_XZ_FIN: st_d = xz_q ? ritpc_pkg::ST_OUT : ritpc_pkg::ST_XZ_A;
      ritpc_pkg::ST_OUT:
        if (out_free) st_d = ritpc_pkg::ST_IDLE;
      default:              st_d = ritpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ritpc_pkg::ST_IDLE;
      fn_q    <= '0;
      step_q  <= '0;
      xz_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      unique case (st_q)
        ritpc_pkg::ST_IDLE: begin
          fn_q <= '0;
          xz_q <= 1'b0;
        end
        ritpc_pkg::ST_SIN_INIT: step_q <= '0;
        ritpc_pkg::ST_POLY:     step_q <= step_q + 3'd1;
        ritpc_pkg::ST_SIN_FIN:  fn_q <= fn_q + 2'd1;
        ritpc_pkg::ST_XZ_FIN:   xz_q <= 1'b1;
        ritpc_pkg::ST_OUT:      if (out_free) out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) smp_q <= q_data_i;
    unique case (st_q)
      ritpc_pkg::ST_SIN_INIT: begin
        u_q   <= {1'b0, t, 16'h0};
        u2_q  <= {1'b0, prod[61:30]};
        p_q   <= {1'b0, ritpc_pkg::K9};
        neg_q <= ang[15];
      end
      ritpc_pkg::ST_POLY: p_q <= {1'b0, kcoef} - {1'b0, prod[61:30]};
      ritpc_pkg::ST_SIN_FIN: begin
        case (fn_q)
          2'd0:    begin sp_q <= sres; spn_q <= neg_q; end
          2'd1:    begin cp_q <= sres; cpn_q <= neg_q; end
          2'd2:    begin sy_q <= sres; syn_q <= neg_q; end
          default: begin cy_q <= sres; cyn_q <= neg_q; end
        endcase
      end
      ritpc_pkg::ST_Y: acc_q <= prod;
      ritpc_pkg::ST_Y_FIN: y_q <= y_new;
      ritpc_pkg::ST_XZ_A: acc_q <= prod;
      ritpc_pkg::ST_XZ_B: acc_q <= prod;
      ritpc_pkg::ST_XZ_FIN: begin
        if (!xz_q) begin
          x_q <= ritpc_pkg::finish(48'((acc_q + 64'h20000000) >> 30),
                                   (cpn_q && cp_q != 16'd0) != (syn_q && sy_q != 16'd0));
        end else begin
          z_q <= ritpc_pkg::finish(48'((acc_q + 64'h20000000) >> 30),
                                   !((cpn_q && cp_q != 16'd0) != (cyn_q && cy_q != 16'd0)));
        end
      end
      ritpc_pkg::ST_OUT: begin
        if (out_free) begin
          out_q.x   <= x_q;
          out_q.y   <= y_q;
          out_q.z   <= z_q;
          out_q.row <= smp_q.row;
          out_q.col <= smp_q.col;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  pop_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> st_q == ritpc_pkg::ST_IDLE) else $error("pop outside idle");
  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q) else $error("result dropped");
  no_overwrite_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> $stable(out_q)) else $error("result overwritten");

endmodule

/* hw/rtl/range_image_to_point_cloud_unit.sv */
// top level of the range image to point cloud unit
// back end: one sample at a time, since all steps share one 32x32 multiplier: four sine
//   polynomials, y product and, for a kept point only, two 2-step x/z products
// a two-entry queue and the output register let front and back end stall on their own
// reset: asynchronous active low; registers to defaults, counters to zero
module range_image_to_point_cloud_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [24:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // distance[23:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [103:0] m_axis_tdata   // x[24:0] y[49:25] z[74:50] row[84:75] col[96:85]
);

  ritpc_pkg::q_status_t q_stat;
  ritpc_pkg::sample_t   push_data, pop_data;
  ritpc_pkg::point_t    pt;
  logic        push, pop;
  logic [23:0] max_dist;
  logic [24:0] min_height;

  ritpc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_dist_i(s_axis_tdata),
    .q_stat_i(q_stat), .q_push_o(push), .q_data_o(push_data),
    .max_dist_o(max_dist), .min_height_o(min_height)
  );

  ritpc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .pop_data_o(pop_data), .stat_o(q_stat)
  );

  ritpc_back u_back (
    .clk_i, .rst_ni, .q_stat_i(q_stat), .q_data_i(pop_data), .q_pop_o(pop),
    .max_dist_i(max_dist), .min_height_i(min_height),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(pt)
  );

  assign m_axis_tdata = {7'd0, pt.col, pt.row, pt.z, pt.y, pt.x};

endmodule
